>>> rtl/core/rphe_pkg.sv
// shared types, constants and round helpers for the reduced panama hash engine
`timescale 1ns / 1ps
`default_nettype none
package rphe_pkg;

  localparam int STATE_WORDS   = 17;
  localparam int STAGE_WORDS   = 8;
  localparam int BUFFER_STAGES = 32;
  localparam int BLANK_PULLS   = 32;
  localparam int PULL_ROUNDS   = BLANK_PULLS + 1;
  localparam int CNT_W         = $clog2(PULL_ROUNDS + 1);

  typedef logic [31:0] word_t;
  typedef word_t [STATE_WORDS-1:0] mix_t;
  typedef word_t [STAGE_WORDS-1:0] stage_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PULL,
    ST_DONE
  } ctl_state_t;

  typedef struct packed {
    logic push;
    logic pull;
    logic clear_all;
  } ctl_cmd_t;

  // pi source index for word j
  function automatic int pi_src(input int j);
    pi_src = (j * 7) % STATE_WORDS;
  endfunction

  // pi rotate amount for word j: triangular number mod 32
  function automatic int pi_rot(input int j);
    pi_rot = ((j * (j + 1)) / 2) % 32;
  endfunction

  function automatic word_t rotl(input word_t v, input int s);
    word_t r;
    r = v;
    if (s != 0) begin
      r = (v << s) | (v >> (32 - s));
    end
    return r;
  endfunction

  // gamma, pi, theta, then injection of q and bst
  function automatic mix_t run_round(input mix_t s, input stage_t q, input stage_t bst);
    mix_t gam;
    mix_t pi;
    mix_t th;
    mix_t res;
    for (int j = 0; j < STATE_WORDS; j++) begin
      gam[j] = s[j] ^ (s[(j + 1) % STATE_WORDS] | ~s[(j + 2) % STATE_WORDS]);
    end
    for (int j = 0; j < STATE_WORDS; j++) begin
      pi[j] = rotl(gam[pi_src(j)], pi_rot(j));
    end
    for (int j = 0; j < STATE_WORDS; j++) begin
      th[j] = pi[j] ^ pi[(j + 1) % STATE_WORDS] ^ pi[(j + 4) % STATE_WORDS];
    end
    res[0] = th[0] ^ 32'h0000_0001;
    for (int j = 0; j < STAGE_WORDS; j++) begin
      res[j + 1] = th[j + 1] ^ q[j];
      res[j + 9] = th[j + 9] ^ bst[j];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/rphe_ctrl.sv
// sequencer for push and blank pull rounds and result handshake
`timescale 1ns / 1ps
`default_nettype none
module rphe_ctrl
  import rphe_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_operation,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  output ctl_cmd_t      cmd
);

  ctl_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid && in_operation) begin
          state_nxt = ST_PULL;
        end
      end
      ST_PULL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(PULL_ROUNDS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    cmd.push      = 1'b0;
    cmd.pull      = 1'b0;
    cmd.clear_all = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.push = in_valid;
      end
      ST_PULL: cmd.pull = 1'b1;
      ST_DONE: begin
        out_valid     = 1'b1;
        cmd.clear_all = !out_stall;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/rphe_datapath.sv
// state words, lfsr buffer shift line and round logic
`timescale 1ns / 1ps
`default_nettype none
module rphe_datapath
  import rphe_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire ctl_cmd_t cmd,
  input  wire logic   in_operation,
  input  wire stage_t in_blk,
  input  wire logic [7:0] in_valid_bits,
  output logic [39:0] digest
);

  mix_t   st_r, st_nxt;
  stage_t buf_r [BUFFER_STAGES];
  stage_t buf_nxt [BUFFER_STAGES];
  stage_t blk;
  stage_t zero_stage;
  stage_t t0_rot;
  mix_t   push_res, pull_res;
  logic [2:0] wi;
  logic [4:0] bi;

  assign zero_stage = '0;
  assign wi = in_valid_bits[7:5];
  assign bi = in_valid_bits[4:0];

  // pad the final block: clear at and above the count, set the pad bit
  always_comb begin
    for (int j = 0; j < STAGE_WORDS; j++) begin
      blk[j] = in_blk[j];
      if (in_operation) begin
        if (3'(j) > wi) begin
          blk[j] = '0;
        end else if (3'(j) == wi) begin
          blk[j] = (in_blk[j] & ~(32'hFFFF_FFFF << bi)) | (32'h1 << bi);
        end
      end
    end
  end

  // push sees a cleared buffer; pull reads stages 4 and 16 of the line
  assign push_res = run_round(st_r, blk, zero_stage);
  assign pull_res = run_round(st_r, buf_r[4], buf_r[16]);

  always_comb begin
    for (int j = 0; j < STAGE_WORDS; j++) begin
      t0_rot[j] = buf_r[BUFFER_STAGES-1][(j + 2) % STAGE_WORDS];
    end
  end

  // next state and buffer
  always_comb begin
    st_nxt = st_r;
    for (int p = 0; p < BUFFER_STAGES; p++) begin
      buf_nxt[p] = buf_r[p];
    end
    if (cmd.clear_all) begin
      st_nxt = '0;
      for (int p = 0; p < BUFFER_STAGES; p++) begin
        buf_nxt[p] = '0;
      end
    end else if (cmd.push) begin
      st_nxt    = '0;
      st_nxt[0] = push_res[0];
      st_nxt[1] = {24'h0, push_res[1][7:0]};
      for (int p = 0; p < BUFFER_STAGES; p++) begin
        buf_nxt[p] = '0;
      end
    end else if (cmd.pull) begin
      st_nxt = pull_res;
      for (int p = 1; p < BUFFER_STAGES; p++) begin
        buf_nxt[p] = buf_r[p-1];
      end
      buf_nxt[25] = buf_r[24] ^ t0_rot;
      buf_nxt[0]  = buf_r[BUFFER_STAGES-1] ^ stage_t'(st_r[8:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
      for (int p = 0; p < BUFFER_STAGES; p++) begin
        buf_r[p] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      for (int p = 0; p < BUFFER_STAGES; p++) begin
        buf_r[p] <= buf_nxt[p];
      end
    end
  end

  assign digest = {st_r[1][7:0], st_r[0]};

endmodule
`default_nettype wire

>>> rtl/core/reduced_panama_hash_engine_unit.sv
// Reduced panama hash engine, 40-bit digest.
// Input channel: one beat carries an 8-word block, an operation bit and,
// for a final block, the valid bit count used for padding.
// An absorb beat runs one push round in the accepting cycle, keeps state
// word 0 and the low byte of word 1 and clears the rest; one beat per cycle
// is taken while no final is in progress.
// A final beat pads, pushes, then runs 33 blank pull rounds, one per cycle,
// over a 32-stage shift line; out_valid rises after the last pull round
// and the digest is taken at the first edge with out_stall low.
// A final block occupies the engine through the pull loop until its digest is taken.
// The input is stalled while a final is in progress or its digest waits.
// If the receiver stalls, out_valid and out_digest hold until taken; taking
// the digest clears all state for the next message.
// Reset (synchronous, active low) clears state, buffer and sequencer.
`timescale 1ns / 1ps
`default_nettype none
module reduced_panama_hash_engine_unit
  import rphe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_operation,
  input  wire logic [31:0] in_msg_word_0,
  input  wire logic [31:0] in_msg_word_1,
  input  wire logic [31:0] in_msg_word_2,
  input  wire logic [31:0] in_msg_word_3,
  input  wire logic [31:0] in_msg_word_4,
  input  wire logic [31:0] in_msg_word_5,
  input  wire logic [31:0] in_msg_word_6,
  input  wire logic [31:0] in_msg_word_7,
  input  wire logic [7:0]  in_valid_bits,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [39:0]      out_digest
);

  ctl_cmd_t cmd;
  stage_t   blk;

  assign blk = {in_msg_word_7, in_msg_word_6, in_msg_word_5, in_msg_word_4,
                in_msg_word_3, in_msg_word_2, in_msg_word_1, in_msg_word_0};

  rphe_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd)
  );

  rphe_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_operation  (in_operation),
    .in_blk        (blk),
    .in_valid_bits (in_valid_bits),
    .digest        (out_digest)
  );

endmodule
`default_nettype wire
